@@ src/multi_mode_plc_timer_top_macros.svh @@
// Assertion macros shared by the timer checker.
`ifndef MULTI_MODE_PLC_TIMER_TOP_MACROS_SVH
`define MULTI_MODE_PLC_TIMER_TOP_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define MMPT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define MMPT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/mmpt_pkg.sv @@
// Types and constants of the multi-mode PLC timer.
`default_nettype none
package mmpt_pkg;

  localparam int unsigned MODE_W    = 3;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [MODE_W-1:0] MODE_ON_DELAY  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_OFF_DELAY = 3'd1;
  localparam logic [MODE_W-1:0] MODE_BLEEP     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PULSE     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TOGGLE    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESET = 2'd1;

  typedef struct packed {
    logic              out_bit;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] start_stamp;
    logic              start_pending;
    logic              end_pending;
  } timer_state_t;

endpackage
`default_nettype wire

@@ src/mmpt_in_if.sv @@
// Input channel: valid/ready with input level and millisecond time.
`default_nettype none
interface mmpt_in_if;
  logic        valid;
  logic        ready;
  logic        in_level;
  logic [31:0] now_ms;

  modport source (output valid, output in_level, output now_ms, input ready);
  modport sink   (input valid, input in_level, input now_ms, output ready);
endinterface
`default_nettype wire

@@ src/mmpt_out_if.sv @@
// Result channel: valid/ready with timer output and elapsed time.
`default_nettype none
interface mmpt_out_if;
  logic        valid;
  logic        ready;
  logic        q_out;
  logic [31:0] elapsed_ms;

  modport source (output valid, output q_out, output elapsed_ms, input ready);
  modport sink   (input valid, input q_out, input elapsed_ms, output ready);
endinterface
`default_nettype wire

@@ src/mmpt_step.sv @@
// Next-state logic of the timer for one input item.
`default_nettype none
module mmpt_step (
  input  wire logic [mmpt_pkg::MODE_W-1:0] mode,
  input  wire logic [mmpt_pkg::TIME_W-1:0] preset_ms,
  input  wire logic                        in_level,
  input  wire logic [mmpt_pkg::TIME_W-1:0] now_ms,
  input  wire mmpt_pkg::timer_state_t      cur,
  output mmpt_pkg::timer_state_t           nxt
);
  import mmpt_pkg::*;

  logic [TIME_W-1:0] base;
  logic [TIME_W-1:0] diff;
  logic              reach;
  logic              active;
  logic              ep_mid;

  // Single time subtractor; base picks the stamp the mode measures from.
  always_comb begin
    case (mode)
      MODE_ON_DELAY, MODE_OFF_DELAY, MODE_TOGGLE: base = cur.start_pending ? now_ms
                                                                           : cur.start_stamp;
      MODE_PULSE: base = in_level ? cur.start_stamp : now_ms;
      default:    base = cur.start_stamp;
    endcase
  end

  assign diff   = now_ms - base;
  assign reach  = (diff >= preset_ms);
  assign active = (mode == MODE_ON_DELAY) ? in_level : ~in_level;
  assign ep_mid = ~in_level | cur.end_pending;

  always_comb begin
    nxt = cur;
    case (mode)
      MODE_ON_DELAY, MODE_OFF_DELAY: begin
        nxt.out_bit = 1'b0;
        if (!active) begin
          nxt.elapsed       = '0;
          nxt.start_pending = 1'b1;
          nxt.end_pending   = 1'b1;
        end else begin
          nxt.start_pending = 1'b0;
          nxt.start_stamp   = base;
          nxt.elapsed       = diff;
          if (reach && cur.end_pending) begin
            nxt.end_pending = 1'b0;
            nxt.out_bit     = 1'b1;
          end
        end
      end
      MODE_BLEEP: begin
        nxt.out_bit = 1'b0;
        if (!in_level) begin
          nxt.start_stamp = now_ms;
          nxt.elapsed     = '0;
        end else if (reach) begin
          nxt.start_stamp = now_ms;
          nxt.elapsed     = '0;
          nxt.out_bit     = 1'b1;
        end else begin
          nxt.elapsed = diff;
        end
      end
      MODE_PULSE: begin
        nxt.start_stamp = base;
        if (ep_mid) begin
          nxt.elapsed     = diff;
          nxt.end_pending = ~reach;
        end else begin
          nxt.elapsed     = '0;
          nxt.end_pending = 1'b0;
        end
        nxt.out_bit = in_level & ep_mid & ~reach;
      end
      MODE_TOGGLE: begin
        if (!in_level) begin
          nxt.start_pending = 1'b1;
          nxt.start_stamp   = now_ms;
          nxt.elapsed       = '0;
        end else begin
          nxt.start_pending = 1'b0;
          if (reach) begin
            nxt.out_bit     = ~cur.out_bit;
            nxt.start_stamp = now_ms;
            nxt.elapsed     = '0;
          end else begin
            nxt.start_stamp = base;
            nxt.elapsed     = diff;
          end
        end
      end
      default: nxt.out_bit = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

@@ src/multi_mode_plc_timer_top.sv @@
// Top level of the multi-mode PLC timer.
// The timer takes transfers on in_ch (input level plus a free-running millisecond
// time stamp) and returns exactly one result per item on out_ch: the timer output
// q_out and the elapsed time in ms. Throughput is one item per cycle unless out_ch
// stalls; the result is registered and appears in the cycle after the input
// transfer. A single subtract-and-compare path feeds the timer state registers,
// so every item sees the state left by the one before. in_ch.ready stays high
// while the result register is empty or being drained in the same cycle. mode and
// preset_ms are written through cfg_we/cfg_idx/cfg_wdata (index 0 mode, index 1
// preset; other indexes are ignored) and must only change while the timer is idle.
// Modes: 0 on-delay and 1 off-delay give a one-item pulse once the active level has
// lasted preset_ms; 2 bleep pulses every preset_ms while the input is high; 3 pulse
// holds q_out high for preset_ms after the input rises; 4 toggle flips q_out every
// preset_ms while the input is high. Codes 5 to 7 force q_out low and hold state.
// Elapsed time uses wrap-around 32-bit subtraction.
`default_nettype none
module multi_mode_plc_timer_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [mmpt_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [mmpt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  mmpt_in_if.sink                             in_ch,
  mmpt_out_if.source                          out_ch
);
  import mmpt_pkg::*;

  // Configuration registers
  logic [MODE_W-1:0] mode_r;
  logic [TIME_W-1:0] preset_r;

  // Timer state
  timer_state_t state_r;
  timer_state_t state_nxt;

  // Result register
  logic              out_valid_r;
  logic              q_r;
  logic [TIME_W-1:0] elapsed_r;

  logic in_xfer;

  // Result register can take a new item when empty or drained this cycle.
  assign in_ch.ready = ~out_valid_r | out_ch.ready;
  assign in_xfer     = in_ch.valid & in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_ON_DELAY;
      preset_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_MODE:   mode_r   <= cfg_wdata[MODE_W-1:0];
        REG_PRESET: preset_r <= cfg_wdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  mmpt_step u_step (
    .mode      (mode_r),
    .preset_ms (preset_r),
    .in_level  (in_ch.in_level),
    .now_ms    (in_ch.now_ms),
    .cur       (state_r),
    .nxt       (state_nxt)
  );

  // State advances only on an accepted input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.out_bit       <= 1'b0;
      state_r.elapsed       <= '0;
      state_r.start_stamp   <= '0;
      state_r.start_pending <= 1'b1;
      state_r.end_pending   <= 1'b1;
    end else if (in_xfer) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload loads with each accepted item; held while the sink stalls.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      q_r       <= state_nxt.out_bit;
      elapsed_r <= state_nxt.elapsed;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.q_out      = q_r;
  assign out_ch.elapsed_ms = elapsed_r;

endmodule
`default_nettype wire

@@ src/mmpt_checker.sv @@
// Port-level checker for the timer, bound to the top level.
`default_nettype none
`include "multi_mode_plc_timer_top_macros.svh"
module mmpt_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        q_out,
  input wire logic [31:0] elapsed_ms
);

  // Stalled result holds its value
  `MMPT_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(q_out) && $stable(elapsed_ms), "result changed while stalled")

  // Every input transfer yields a result the next cycle
  `MMPT_ASSERT(a_in_to_out, clk, rst_n, in_valid && in_ready |=> out_valid, "no result after input transfer")

  // No input taken while the result register is full and stalled
  `MMPT_ASSERT(a_no_overrun, clk, rst_n, out_valid && !out_ready |-> !in_ready, "input accepted over a stalled result")

  // Drained result without new input leaves the channel empty
  `MMPT_ASSERT(a_no_invent, clk, rst_n, $past(rst_n) && $past(out_valid && out_ready) && !$past(in_valid && in_ready) |-> !out_valid, "result appeared without input")

endmodule

bind multi_mode_plc_timer_top mmpt_checker u_mmpt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .q_out      (out_ch.q_out),
  .elapsed_ms (out_ch.elapsed_ms)
);
`default_nettype wire

@@ sim/timer_result_checker.sv @@
// Result checker for the multi-mode PLC timer: predicts every result and compares it.
`default_nettype none
module timer_result_checker (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [mmpt_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [mmpt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  mmpt_in_if                                   in_ch,
  mmpt_out_if                                  out_ch,
  output int                                   error_total,
  output int                                   results_owed
);
  import mmpt_pkg::*;

  typedef struct packed {
    logic              q;
    logic [TIME_W-1:0] elapsed;
  } timer_result_t;

  timer_result_t     owed_results[$];
  logic [MODE_W-1:0] mode_reg;
  logic [TIME_W-1:0] preset_reg;
  timer_state_t      st;

  // One timer update; advances the mirrored state.
  function automatic timer_result_t advance_timer(input logic lvl,
                                                  input logic [TIME_W-1:0] now);
    logic active;
    case (mode_reg)
      MODE_ON_DELAY, MODE_OFF_DELAY: begin
        active = (mode_reg == MODE_ON_DELAY) ? lvl : !lvl;
        st.out_bit = 1'b0;
        if (!active) begin
          st.elapsed       = '0;
          st.start_pending = 1'b1;
          st.end_pending   = 1'b1;
        end else begin
          if (st.start_pending) begin
            st.start_pending = 1'b0;
            st.start_stamp   = now;
          end
          st.elapsed = now - st.start_stamp;
          if (st.elapsed >= preset_reg && st.end_pending) begin
            st.end_pending = 1'b0;
            st.out_bit     = 1'b1;
          end
        end
      end
      MODE_BLEEP: begin
        if (!lvl) begin
          st.start_stamp = now;
          st.elapsed     = '0;
          st.out_bit     = 1'b0;
        end else begin
          st.elapsed = now - st.start_stamp;
          if (st.elapsed >= preset_reg) begin
            st.start_stamp = now;
            st.elapsed     = '0;
            st.out_bit     = 1'b1;
          end else begin
            st.out_bit = 1'b0;
          end
        end
      end
      MODE_PULSE: begin
        if (!lvl) begin
          st.start_stamp = now;
          st.end_pending = 1'b1;
        end
        // with a zero preset end_pending clears even while low
        if (st.end_pending) begin
          st.elapsed = now - st.start_stamp;
          if (st.elapsed >= preset_reg) st.end_pending = 1'b0;
        end else begin
          st.elapsed = '0;
        end
        st.out_bit = lvl && st.end_pending;
      end
      MODE_TOGGLE: begin
        if (!lvl) begin
          st.start_pending = 1'b1;
          st.start_stamp   = now;
          st.elapsed       = '0;
        end else begin
          if (st.start_pending) begin
            st.start_pending = 1'b0;
            st.start_stamp   = now;
          end
          st.elapsed = now - st.start_stamp;
          if (st.elapsed >= preset_reg) begin
            st.out_bit     = !st.out_bit;
            st.start_stamp = now;
            st.elapsed     = '0;
          end
        end
      end
      default: st.out_bit = 1'b0;   // unused codes: output low, state held
    endcase
    return '{q: st.out_bit, elapsed: st.elapsed};
  endfunction

  function automatic void log_mismatch(string what, logic [TIME_W-1:0] want,
                                       logic [TIME_W-1:0] got);
    error_total++;
    if (error_total <= 10)
      $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, what, want, got);
  endfunction

  always @(posedge clk) begin
    timer_result_t got, want;
    if (!rst_n) begin
      mode_reg         = MODE_ON_DELAY;
      preset_reg       = '0;
      st.out_bit       = 1'b0;
      st.elapsed       = '0;
      st.start_stamp   = '0;
      st.start_pending = 1'b1;
      st.end_pending   = 1'b1;
      owed_results.delete();
      error_total      = 0;
    end else begin
      // result side first: results are registered, so none leaves with its own input
      if (out_ch.valid && out_ch.ready) begin
        got = '{q: out_ch.q_out, elapsed: out_ch.elapsed_ms};
        if (owed_results.size() == 0) begin
          error_total++;
          if (error_total <= 10)
            $display("%0t: result transfer with none expected: q_out %0b elapsed %0h",
                     $realtime, got.q, got.elapsed);
        end else begin
          want = owed_results.pop_front();
          if (got.q !== want.q) log_mismatch("q_out", want.q, got.q);
          if (got.elapsed !== want.elapsed)
            log_mismatch("elapsed_ms", want.elapsed, got.elapsed);
        end
      end
      if (in_ch.valid && in_ch.ready)
        owed_results.push_back(advance_timer(in_ch.in_level, in_ch.now_ms));
      if (cfg_we) begin
        if (cfg_idx == REG_MODE) mode_reg = cfg_wdata[MODE_W-1:0];
        else if (cfg_idx == REG_PRESET) preset_reg = cfg_wdata[TIME_W-1:0];
      end
    end
    results_owed = owed_results.size();
  end

endmodule
`default_nettype wire

@@ sim/tb_multi_mode_plc_timer_top.sv @@
// Testbench top for the multi-mode PLC timer: clock, reset, stimulus and verdict.
`default_nettype none
module tb_multi_mode_plc_timer_top;
  import mmpt_pkg::*;

  // Watchdog: cycles in a row with no transfer on either channel.
  // Longest correct stall is a receiver gap at 77% idle, well under this.
  localparam int STALL_LIMIT     = 2000;
  localparam int ITEMS_PER_PHASE = 430;

  // Register indexes past the two real registers; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  // First of the unused mode codes (5..7).
  localparam logic [MODE_W-1:0]    MODE_SPARE_FIRST = 3'd5;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int unsigned       send_gap_pct;
  int unsigned       recv_gap_pct;
  logic [TIME_W-1:0] clock_ms;
  int                error_total;
  int                results_owed;
  int                quiet_cycles = 0;

  mmpt_in_if  in_ch ();
  mmpt_out_if out_ch ();

  multi_mode_plc_timer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  timer_result_checker u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_wdata    (cfg_wdata),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .error_total  (error_total),
    .results_owed (results_owed)
  );

  always #2 clk = ~clk;

  // Receiver back-pressure, redrawn every falling edge.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_gap_pct);
  end

  // Watchdog on transfers; also catches a result that never shows up.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One input transfer. Entered and left at a falling edge; valid is not dropped on
  // exit, so back-to-back items keep it high.
  task automatic send_item(input logic lvl, input logic [TIME_W-1:0] t);
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.in_level <= lvl;
    in_ch.now_ms   <= t;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Wait until every expected result has come back and the result register has
  // drained, so the timer is idle before a register write.
  task automatic drain_timer();
    in_ch.valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // Mode word may carry junk above the 3-bit field; only the low bits count.
  task automatic program_timer(input logic [MODE_W-1:0] m,
                               input logic [CFG_DATA_W-1:0] preset);
    logic [CFG_DATA_W-1:0] mode_word;
    mode_word = ($urandom_range(9) == 0) ? $urandom() : '0;
    mode_word[MODE_W-1:0] = m;
    drain_timer();
    write_reg(REG_MODE, mode_word);
    write_reg(REG_PRESET, preset);
  endtask

  // Mostly small presets so the timers actually expire; extremes now and then.
  function automatic logic [CFG_DATA_W-1:0] pick_preset();
    case ($urandom_range(9))
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom();
      3:       return $urandom_range(1000, 100);
      default: return $urandom_range(20, 1);
    endcase
  endfunction

  // Time advance between items: usually a few ms, sometimes a long jump (wraps).
  function automatic logic [TIME_W-1:0] time_step();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 70) return $urandom_range(4);
    if (roll < 90) return $urandom_range(40);
    if (roll < 97) return $urandom_range(1000);
    return $urandom();
  endfunction

  initial begin
    logic        lvl;
    logic        noise;
    int          run_left;
    int          seg_len;
    int          sent;
    logic [MODE_W-1:0] m;

    // everything known from time zero
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = '0;
    cfg_wdata      = '0;
    in_ch.valid    = 1'b0;
    in_ch.in_level = 1'b0;
    in_ch.now_ms   = '0;
    out_ch.ready   = 1'b0;
    send_gap_pct   = 8;
    recv_gap_pct   = 77;
    clock_ms       = $urandom();

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // ---- directed part ----
    // On-delay with zero preset: pulse on the very first active item only.
    program_timer(MODE_ON_DELAY, '0);
    send_item(1'b0, 32'd10);
    send_item(1'b1, 32'd11);
    send_item(1'b1, 32'd12);
    // On-delay, all-ones preset, start just below the wrap: elapsed goes through
    // the wrap and hits 2^32-1 exactly once before the input drops.
    program_timer(MODE_ON_DELAY, 32'hFFFF_FFFF);
    send_item(1'b1, 32'hFFFF_FFF0);
    send_item(1'b1, 32'h0000_0005);
    send_item(1'b1, 32'hFFFF_FFEF);
    send_item(1'b0, 32'hFFFF_FFEF);
    // Off-delay: active while the input is low.
    program_timer(MODE_OFF_DELAY, 32'd3);
    send_item(1'b1, 32'd20);
    send_item(1'b0, 32'd21);
    send_item(1'b0, 32'd24);
    send_item(1'b0, 32'd30);
    // Bleep: restamps on every pulse.
    program_timer(MODE_BLEEP, 32'd2);
    send_item(1'b0, 32'd40);
    send_item(1'b1, 32'd41);
    send_item(1'b1, 32'd43);
    send_item(1'b1, 32'd44);
    // Pulse with zero preset: end flag clears while low, output never rises.
    program_timer(MODE_PULSE, '0);
    send_item(1'b0, 32'd50);
    send_item(1'b1, 32'd51);
    // Pulse with a real width, then held input past the end.
    program_timer(MODE_PULSE, 32'd4);
    send_item(1'b0, 32'd60);
    send_item(1'b1, 32'd61);
    send_item(1'b1, 32'd65);
    send_item(1'b1, 32'd70);
    // Toggle: first high item only stamps, then flips every preset.
    program_timer(MODE_TOGGLE, 32'd1);
    send_item(1'b0, 32'd80);
    send_item(1'b1, 32'd81);
    send_item(1'b1, 32'd82);
    send_item(1'b1, 32'd83);
    // Unused mode codes: output low, state untouched.
    for (int k = 0; k < 3; k++) begin
      program_timer(MODE_SPARE_FIRST + MODE_W'(k), 32'd5);
      send_item(1'b1, 32'd90 + k);
    end
    // Writes to indexes past the register file change nothing.
    program_timer(MODE_TOGGLE, 32'd1);
    write_reg(REG_SPARE_A, $urandom());
    write_reg(REG_SPARE_B, $urandom());
    send_item(1'b1, 32'd100);

    // ---- random part, three idling phases ----
    lvl = 1'b0;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_gap_pct = 8;  recv_gap_pct = 77; end
        1: begin send_gap_pct = 77; recv_gap_pct = 8;  end
        default: begin send_gap_pct = 0; recv_gap_pct = 0; end
      endcase
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        m = ($urandom_range(9) == 0) ? MODE_W'($urandom_range(7, 5))
                                     : MODE_W'($urandom_range(4));
        program_timer(m, pick_preset());
        seg_len  = $urandom_range(60, 20);
        run_left = 0;
        // level comes in runs so timers get to expire; a few noisy items mixed in
        repeat (seg_len) begin
          if (run_left == 0) begin
            lvl      = !lvl;
            run_left = $urandom_range(10, 1);
          end
          run_left--;
          noise = 1'($urandom_range(1));
          send_item(($urandom_range(19) == 0) ? noise : lvl, clock_ms);
          clock_ms += time_step();
        end
        sent += seg_len;
      end
    end

    drain_timer();
    if (error_total == 0 && results_owed == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
